### hw/rtl/dbpsk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbpsk_pkg
// shared types and constants for the dbpsk chip encoder and packer
// ----------------------------------------------------------------------------
package dbpsk_pkg;

  // request mode codes
  localparam logic [1:0] MODE_ENCODE = 2'd0;
  localparam logic [1:0] MODE_RAW    = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // configuration register indexes
  localparam logic CFG_CPS = 1'b0;
  localparam logic CFG_CAP = 1'b1;

  localparam logic [5:0]  CPS_RESET  = 6'd8;
  localparam logic [15:0] CAP_RESET  = 16'hffff;
  localparam logic [3:0]  FULL_CHIPS = 4'd8;
  localparam logic [2:0]  LAST_BIT   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FLUSH
  } seq_state_t;

  // sequencer to packer
  typedef struct packed {
    logic step;
    logic chip;
    logic clear;
  } pk_ctrl_t;

  // packer to sequencer
  typedef struct packed {
    logic       completes;
    logic [7:0] full_byte;
    logic [7:0] flush_byte;
    logic [3:0] fill_cnt;
    logic       dropped;
  } pk_stat_t;

endpackage
`default_nettype wire

### hw/rtl/dbpsk_chip_encoder_packer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbpsk_chip_encoder_packer_top
// dbpsk differential chip encoder with msb-first byte packing
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request per item. mode encode
//   expands data_byte msb first, each bit into chips_per_symbol chips
//   (a zero bit starts with a one chip); mode raw appends raw_chip
//   repeat_count times; mode flush emits the partial byte padded with zeros
//   and starts a new frame. mode 3 and raw with count zero do nothing.
//   output channel (out_valid / out_stall): one request per packed byte,
//   run_last marks the final byte of an item, frame_end the flush byte.
//   config port: cfg_we writes cfg_wdata into register cfg_index; user must write only while idle (not enforced).
// timing
//   the packer takes one chip per cycle unless the chip loop is stalled on
//   the output. an item runs its chips, then drains its last held byte;
//   a flush loads the flush byte once the output register is free.
//   in_stall is high from acceptance until done; bytes go out one behind:
//   each is held until the next completes or the item drains.
// reset and backpressure
//   rst_n (sync, low) empties the packer and frame and restores the config
//   defaults. a held output stalls the chip loop only when a second byte
//   completes behind the one already waiting.
// ----------------------------------------------------------------------------
module dbpsk_chip_encoder_packer_top (
  input  wire        clk,
  input  wire        rst_n,
  // configuration
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_wdata,
  // input requests
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  in_mode,
  input  wire [7:0]  in_data_byte,
  input  wire        in_raw_chip,
  input  wire [8:0]  in_repeat_count,
  // output requests
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_packed_byte,
  output logic [3:0] out_valid_chips,
  output logic       out_run_last,
  output logic       out_frame_end,
  output logic       out_overflow
);
  import dbpsk_pkg::*;

  // configuration registers
  logic [5:0]  cps_r;
  logic [15:0] cap_r;
  logic [5:0]  cps_eff;

  // sequencer
  seq_state_t  state_r, state_nxt;
  logic        is_raw_r;
  logic [7:0]  data_r;
  logic        raw_r;
  logic [8:0]  rem_r;
  logic [2:0]  bit_r;
  logic [5:0]  pos_r;

  // one completed byte held back until we know whether it is the last
  logic        pend_v_r;
  logic [7:0]  pend_byte_r;
  logic        pend_ovf_r;

  // output register
  logic        out_v_r;
  logic [7:0]  out_byte_r;
  logic [3:0]  out_cnt_r;
  logic        out_last_r;
  logic        out_fend_r;
  logic        out_ovf_r;

  pk_ctrl_t    pk_ctrl;
  pk_stat_t    pk_stat;

  logic        in_accept;
  logic        out_free;
  logic        cur_chip;
  logic        last_chip;
  logic        sym_end;
  logic        step;
  logic        ld_pend_out;
  logic        ld_flush_out;

  assign cps_eff   = (cps_r == 6'd0) ? 6'd1 : cps_r;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_v_r || !out_stall;
  assign sym_end   = (pos_r == cps_eff - 6'd1);
  // a zero data bit flips phase on the first chip of its symbol
  assign cur_chip  = is_raw_r ? raw_r : (!data_r[bit_r] && (pos_r == 6'd0));
  assign last_chip = is_raw_r ? (rem_r == 9'd1) : ((bit_r == 3'd0) && sym_end);

  dbpsk_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_cap (cap_r),
    .ctrl      (pk_ctrl),
    .stat      (pk_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cps_r <= CPS_RESET;
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CPS: cps_r <= cfg_wdata[5:0];
        CFG_CAP: cap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_ENCODE: state_nxt = ST_RUN;
            MODE_RAW:    state_nxt = (in_repeat_count != 9'd0) ? ST_RUN : ST_IDLE;
            MODE_FLUSH:  state_nxt = ST_FLUSH;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (step && last_chip) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pend_v_r || out_free) state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = 1'b1;
    step          = 1'b0;
    ld_pend_out   = 1'b0;
    ld_flush_out  = 1'b0;
    pk_ctrl.chip  = cur_chip;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN: begin
        // hold the loop only when a second byte would pile up behind a full output
        step        = !(pk_stat.completes && pend_v_r && !out_free);
        ld_pend_out = step && pk_stat.completes && pend_v_r;
      end
      ST_DRAIN: ld_pend_out  = pend_v_r && out_free;
      ST_FLUSH: ld_flush_out = out_free;
      default: ;
    endcase
    pk_ctrl.step  = step;
    pk_ctrl.clear = ld_flush_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN && step && pk_stat.completes) begin
        pend_v_r <= 1'b1;
      end else if (state_r == ST_DRAIN && out_free) begin
        pend_v_r <= 1'b0;
      end
      if (ld_pend_out || ld_flush_out) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // item registers and chip counters
  always_ff @(posedge clk) begin
    if (in_accept) begin
      is_raw_r <= (in_mode == MODE_RAW);
      data_r   <= in_data_byte;
      raw_r    <= in_raw_chip;
      rem_r    <= in_repeat_count;
      bit_r    <= LAST_BIT;
      pos_r    <= 6'd0;
    end else if (state_r == ST_RUN && step) begin
      rem_r <= rem_r - 9'd1;
      if (sym_end) begin
        pos_r <= 6'd0;
        bit_r <= bit_r - 3'd1;
      end else begin
        pos_r <= pos_r + 6'd1;
      end
    end
  end

  // pending byte and output payload
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN && step && pk_stat.completes) begin
      pend_byte_r <= pk_stat.full_byte;
      pend_ovf_r  <= pk_stat.dropped;
    end
    if (ld_pend_out) begin
      out_byte_r <= pend_byte_r;
      out_cnt_r  <= FULL_CHIPS;
      out_last_r <= (state_r == ST_DRAIN);
      out_fend_r <= 1'b0;
      out_ovf_r  <= pend_ovf_r;
    end else if (ld_flush_out) begin
      out_byte_r <= pk_stat.flush_byte;
      out_cnt_r  <= pk_stat.fill_cnt;
      out_last_r <= 1'b1;
      out_fend_r <= 1'b1;
      out_ovf_r  <= pk_stat.dropped;
    end
  end

  assign out_valid       = out_v_r;
  assign out_packed_byte = out_byte_r;
  assign out_valid_chips = out_cnt_r;
  assign out_run_last    = out_last_r;
  assign out_frame_end   = out_fend_r;
  assign out_overflow    = out_ovf_r;

endmodule
`default_nettype wire

### hw/rtl/dbpsk_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbpsk_packer
// one-chip-per-step shift packer with frame capacity check and drop flag
// ----------------------------------------------------------------------------
module dbpsk_packer (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire [15:0]               frame_cap,
  input  wire dbpsk_pkg::pk_ctrl_t ctrl,
  output dbpsk_pkg::pk_stat_t      stat
);
  import dbpsk_pkg::*;

  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [15:0] frame_r, frame_nxt;
  logic        drop_r, drop_nxt;
  logic        chip_ok;

  always_comb begin
    chip_ok         = frame_r < frame_cap;
    stat.completes  = chip_ok && (fill_r == LAST_BIT);
    stat.full_byte  = {shift_r[6:0], ctrl.chip};
    stat.flush_byte = shift_r << (FULL_CHIPS - {1'b0, fill_r});
    stat.fill_cnt   = {1'b0, fill_r};
    stat.dropped    = drop_r;
  end

  always_comb begin
    shift_nxt = shift_r;
    fill_nxt  = fill_r;
    frame_nxt = frame_r;
    drop_nxt  = drop_r;
    if (ctrl.clear) begin
      shift_nxt = '0;
      fill_nxt  = '0;
      frame_nxt = '0;
      drop_nxt  = 1'b0;
    end else if (ctrl.step) begin
      if (chip_ok) begin
        frame_nxt = frame_r + 16'd1;
        fill_nxt  = fill_r + 3'd1;   // wraps to zero on a full byte
        shift_nxt = stat.completes ? 8'd0 : {shift_r[6:0], ctrl.chip};
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      fill_r  <= '0;
      frame_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      fill_r  <= fill_nxt;
      frame_r <= frame_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule
`default_nettype wire
